>>> rtl/assert_macros.svh
// Assertion macros shared by the periodic tick dispatcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PDT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");
`define PDT_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");
`else
`define PDT_ASSERT(label, clk, rst, prop)
`define PDT_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> rtl/pdt_pkg.sv
// Types and constants of the periodic tick dispatcher.
package pdt_pkg;

   localparam int TICK_W    = 16;
   localparam int SLOT_W    = 4;
   localparam int STATUS_W  = 2;
   localparam int TABLE_CAP = 16;
   localparam int DIV_CNT_W = 4;

   localparam logic [TICK_W-1:0] TICK_LIMIT = 16'hFFFF;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_REG  = 1'b1;

   localparam logic KIND_REPLY = 1'b0;
   localparam logic KIND_FIRE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_CAP,
      S_DRAIN,
      S_REPLY
   } fsm_state_type;

   typedef struct packed {
      logic              clear;
      logic              step;
      logic              dbit;
      logic              capture;
      logic              shift;
      logic              write;
      logic [SLOT_W-1:0] wr_slot;
      logic [TICK_W-1:0] wr_period;
   } cell_ctrl_type;

   typedef struct packed {
      logic              match;
      logic [SLOT_W-1:0] slot;
   } link_type;

endpackage

>>> rtl/pdt_cell.sv
// One watcher cell: stored period, bit-serial remainder and one stage of the result chain.
module pdt_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  pdt_pkg::cell_ctrl_type     ctrl,
   input  logic [pdt_pkg::SLOT_W-1:0] slot_id,
   input  logic                       active,
   input  pdt_pkg::link_type          prev_link,
   output pdt_pkg::link_type          next_link
);

   logic [pdt_pkg::TICK_W-1:0] period_ff;
   logic [pdt_pkg::TICK_W-1:0] rem_ff;
   logic [pdt_pkg::TICK_W-1:0] rem_in;
   logic [pdt_pkg::TICK_W:0]   shifted;
   logic [pdt_pkg::TICK_W:0]   trial;
   pdt_pkg::link_type          link_ff;
   pdt_pkg::link_type          link_in;

   always_comb begin
      shifted = {rem_ff, ctrl.dbit};
      trial   = shifted - {1'b0, period_ff};
      rem_in  = rem_ff;
      if (ctrl.clear) begin
         rem_in = '0;
      end else if (ctrl.step) begin
         if (shifted >= {1'b0, period_ff}) begin
            rem_in = trial[pdt_pkg::TICK_W-1:0];
         end else begin
            rem_in = shifted[pdt_pkg::TICK_W-1:0];
         end
      end
   end

   always_comb begin
      link_in = link_ff;
      if (ctrl.capture) begin
         link_in.match = active && (rem_ff == '0);
         link_in.slot  = slot_id;
      end else if (ctrl.shift) begin
         link_in = prev_link;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff       <= rem_in;
      link_ff.slot <= link_in.slot;
      if (ctrl.write && (ctrl.wr_slot == slot_id)) begin
         period_ff <= ctrl.wr_period;
      end
      if (reset) begin
         link_ff.match <= 1'b0;
      end else begin
         link_ff.match <= link_in.match;
      end
   end

   assign next_link = link_ff;

endmodule

>>> rtl/periodic_tick_dispatcher.sv
// Periodic tick dispatcher: tick counter, row of watcher cells and result sequencer.
//
// Input words (req_valid/req_stall) carry an op and a period. A tick word
// advances the counter, which wraps from its limit back to 1, and then yields
// one fire word per watcher whose period divides the new count, newest slot
// first, the final one marked by rsp_last. A tick with no match yields none.
// A register word stores a period in the next free cell and yields one reply.
// Each cell divides the count by its own period bit-serially, one bit a cycle,
// so a tick passes through division, a capture step and a walk of the result
// chain, one cell at a time. The block takes one word at a time; req_stall is
// high until its results are all loaded into the output register. A stall on
// rsp_stall holds the output word and halts the chain walk only at a matching
// cell. Synchronous reset clears the counter, the watcher count and the output
// valid; stored periods are not cleared and need no clearing pass.
module periodic_tick_dispatcher #(
   parameter int MAX_WATCHERS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_op,
   input  logic [pdt_pkg::TICK_W-1:0]   req_period,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_kind,
   output logic [pdt_pkg::STATUS_W-1:0] rsp_status,
   output logic [pdt_pkg::SLOT_W-1:0]   rsp_slot,
   output logic [pdt_pkg::TICK_W-1:0]   rsp_tick_now,
   output logic                         rsp_last
);

   `include "assert_macros.svh"

   localparam int NCELL = (MAX_WATCHERS > pdt_pkg::TABLE_CAP) ? pdt_pkg::TABLE_CAP
                                                              : MAX_WATCHERS;
   localparam int CNT_W = $clog2(NCELL + 1);
   localparam logic [NCELL-1:0] BELOW_MASK = {NCELL{1'b1}} >> 1;

   pdt_pkg::fsm_state_type state_ff, state_in;
   pdt_pkg::cell_ctrl_type ctrl;
   pdt_pkg::link_type      links [NCELL];
   pdt_pkg::link_type      top_link;
   logic [NCELL-1:0]       match_vec;

   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [CNT_W-1:0]              dcnt_ff, dcnt_in;
   logic [pdt_pkg::DIV_CNT_W-1:0] divc_ff, divc_in;
   logic [pdt_pkg::TICK_W-1:0]    tick_ff, tick_in;
   logic [pdt_pkg::TICK_W-1:0]    div_ff, div_in;
   logic [pdt_pkg::TICK_W-1:0]    now_val;
   logic [pdt_pkg::STATUS_W-1:0]  pend_status_ff, pend_status_in;
   logic [pdt_pkg::SLOT_W-1:0]    pend_slot_ff, pend_slot_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_kind_ff, rsp_kind_in;
   logic [pdt_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [pdt_pkg::SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [pdt_pkg::TICK_W-1:0]   rsp_tick_ff, rsp_tick_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic accept;
   logic out_free;
   logic advance;
   logic table_full;
   logic period_bad;

   genvar gi;
   generate
      for (gi = 0; gi < NCELL; gi++) begin : g_cell
         pdt_pkg::link_type prev;
         if (gi == 0) begin : g_head
            assign prev = '0;
         end else begin : g_body
            assign prev = links[gi-1];
         end
         pdt_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .slot_id   (pdt_pkg::SLOT_W'(gi)),
            .active    (CNT_W'(gi) < cnt_ff),
            .prev_link (prev),
            .next_link (links[gi])
         );
         assign match_vec[gi] = links[gi].match;
      end
   endgenerate

   assign top_link   = links[NCELL-1];
   assign req_stall  = (state_ff != pdt_pkg::S_IDLE);
   assign accept     = req_valid && (state_ff == pdt_pkg::S_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = !top_link.match || out_free;
   assign table_full = (cnt_ff >= CNT_W'(NCELL));
   assign period_bad = (req_period == '0) || (req_period > pdt_pkg::TICK_LIMIT);
   assign now_val    = (tick_ff >= pdt_pkg::TICK_LIMIT) ? pdt_pkg::TICK_W'(1)
                                                        : tick_ff + pdt_pkg::TICK_W'(1);

   always_comb begin
      state_in       = state_ff;
      ctrl           = '0;
      ctrl.dbit      = div_ff[pdt_pkg::TICK_W-1];
      ctrl.wr_slot   = pdt_pkg::SLOT_W'(cnt_ff);
      ctrl.wr_period = req_period;
      cnt_in         = cnt_ff;
      dcnt_in        = dcnt_ff;
      divc_in        = divc_ff;
      tick_in        = tick_ff;
      div_in         = div_ff;
      pend_status_in = pend_status_ff;
      pend_slot_in   = pend_slot_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_kind_in    = rsp_kind_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_tick_in    = rsp_tick_ff;
      rsp_last_in    = rsp_last_ff;
      unique case (state_ff)
         pdt_pkg::S_IDLE: begin
            if (accept) begin
               if (req_op == pdt_pkg::OP_REG) begin
                  pend_slot_in = '0;
                  if (table_full) begin
                     pend_status_in = pdt_pkg::STATUS_FULL;
                  end else if (period_bad) begin
                     pend_status_in = pdt_pkg::STATUS_BAD;
                  end else begin
                     pend_status_in = pdt_pkg::STATUS_OK;
                     pend_slot_in   = pdt_pkg::SLOT_W'(cnt_ff);
                     ctrl.write     = 1'b1;
                     cnt_in         = cnt_ff + CNT_W'(1);
                  end
                  state_in = pdt_pkg::S_REPLY;
               end else begin
                  tick_in    = now_val;
                  div_in     = now_val;
                  divc_in    = '0;
                  ctrl.clear = 1'b1;
                  state_in   = pdt_pkg::S_DIV;
               end
            end
         end
         pdt_pkg::S_DIV: begin
            ctrl.step = 1'b1;
            div_in    = div_ff << 1;
            divc_in   = divc_ff + pdt_pkg::DIV_CNT_W'(1);
            if (divc_ff == '1) begin
               state_in = pdt_pkg::S_CAP;
            end
         end
         pdt_pkg::S_CAP: begin
            ctrl.capture = 1'b1;
            dcnt_in      = '0;
            state_in     = pdt_pkg::S_DRAIN;
         end
         pdt_pkg::S_DRAIN: begin
            if (advance) begin
               ctrl.shift = 1'b1;
               if (top_link.match) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = pdt_pkg::KIND_FIRE;
                  rsp_status_in = pdt_pkg::STATUS_OK;
                  rsp_slot_in   = top_link.slot;
                  rsp_tick_in   = tick_ff;
                  rsp_last_in   = !(|(match_vec & BELOW_MASK));
               end
               if (dcnt_ff == CNT_W'(NCELL - 1)) begin
                  state_in = pdt_pkg::S_IDLE;
               end else begin
                  dcnt_in = dcnt_ff + CNT_W'(1);
               end
            end
         end
         pdt_pkg::S_REPLY: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = pdt_pkg::KIND_REPLY;
               rsp_status_in = pend_status_ff;
               rsp_slot_in   = pend_slot_ff;
               rsp_tick_in   = '0;
               rsp_last_in   = 1'b1;
               state_in      = pdt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pdt_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      dcnt_ff        <= dcnt_in;
      divc_ff        <= divc_in;
      div_ff         <= div_in;
      pend_status_ff <= pend_status_in;
      pend_slot_ff   <= pend_slot_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_tick_ff    <= rsp_tick_in;
      rsp_last_ff    <= rsp_last_in;
      if (reset) begin
         state_ff     <= pdt_pkg::S_IDLE;
         cnt_ff       <= '0;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_slot     = rsp_slot_ff;
   assign rsp_tick_now = rsp_tick_ff;
   assign rsp_last     = rsp_last_ff;

   `PDT_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= CNT_W'(NCELL))
   `PDT_ASSERT(a_fire_ok, clock, reset,
      (rsp_valid && (rsp_kind == pdt_pkg::KIND_FIRE)) |-> (rsp_status == pdt_pkg::STATUS_OK))
   `PDT_ASSERT(a_reply_last, clock, reset,
      (rsp_valid && (rsp_kind == pdt_pkg::KIND_REPLY)) |-> rsp_last)
   `PDT_ASSERT(a_tick_nonzero, clock, reset, (tick_ff != '0) |=> (tick_ff != '0))

endmodule

>>> test/periodic_tick_dispatcher_tb.sv
// Self-checking testbench for the periodic tick dispatcher: directed table, then random words.
module periodic_tick_dispatcher_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHERS       = 16;
   localparam int CAPACITY       = (WATCHERS < pdt_pkg::TABLE_CAP) ? WATCHERS
                                                                   : pdt_pkg::TABLE_CAP;
   localparam int DIRECTED_ROWS  = 25;
   localparam int RANDOM_WORDS   = 75;
   localparam int MAX_GAP        = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 200;

   typedef struct packed {
      logic                         kind;
      logic [pdt_pkg::STATUS_W-1:0] status;
      logic [pdt_pkg::SLOT_W-1:0]   slot;
      logic [pdt_pkg::TICK_W-1:0]   tick_now;
      logic                         last;
   } tick_result_type;

   typedef struct packed {
      logic                       op;
      logic [pdt_pkg::TICK_W-1:0] period;
      logic                       typed;
      tick_result_type            reply;
   } stim_row_type;

   localparam tick_result_type NO_REPLY = '0;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic                         req_op;
   logic [pdt_pkg::TICK_W-1:0]   req_period;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic                         rsp_kind;
   logic [pdt_pkg::STATUS_W-1:0] rsp_status;
   logic [pdt_pkg::SLOT_W-1:0]   rsp_slot;
   logic [pdt_pkg::TICK_W-1:0]   rsp_tick_now;
   logic                         rsp_last;

   tick_result_type            pending_results [$];
   logic [pdt_pkg::TICK_W-1:0] model_tick = '0;
   logic [pdt_pkg::TICK_W-1:0] model_periods [pdt_pkg::TABLE_CAP] = '{default: '0};
   logic [4:0]                 model_watchers = '0;

   bit steady = 1'b0;
   int mismatches = 0;
   int words_sent = 0;
   int ticks_sent = 0;
   int regs_sent = 0;
   int results_seen = 0;
   int fires_seen = 0;
   int quiet_cycles = 0;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{pdt_pkg::OP_TICK, 16'd0,    1'b0, NO_REPLY},
      '{pdt_pkg::OP_REG,  16'd0,    1'b1,
        '{pdt_pkg::KIND_REPLY, pdt_pkg::STATUS_BAD, 4'd0, 16'd0, 1'b1}},
      '{pdt_pkg::OP_REG,  16'hFFFF, 1'b1,
        '{pdt_pkg::KIND_REPLY, pdt_pkg::STATUS_OK, 4'd0, 16'd0, 1'b1}},
      '{pdt_pkg::OP_TICK, 16'hFFFF, 1'b0, NO_REPLY},
      '{pdt_pkg::OP_REG,  16'd1,    1'b1,
        '{pdt_pkg::KIND_REPLY, pdt_pkg::STATUS_OK, 4'd1, 16'd0, 1'b1}},
      '{pdt_pkg::OP_TICK, 16'd0,    1'b0, NO_REPLY},
      '{pdt_pkg::OP_REG,  16'd2,    1'b1,
        '{pdt_pkg::KIND_REPLY, pdt_pkg::STATUS_OK, 4'd2, 16'd0, 1'b1}},
      '{pdt_pkg::OP_TICK, 16'h5A5A, 1'b0, NO_REPLY},
      '{pdt_pkg::OP_REG,  16'd3,    1'b0, NO_REPLY},
      '{pdt_pkg::OP_REG,  16'd4,    1'b0, NO_REPLY},
      '{pdt_pkg::OP_REG,  16'd5,    1'b0, NO_REPLY},
      '{pdt_pkg::OP_REG,  16'd6,    1'b0, NO_REPLY},
      '{pdt_pkg::OP_REG,  16'd8,    1'b0, NO_REPLY},
      '{pdt_pkg::OP_REG,  16'd10,   1'b0, NO_REPLY},
      '{pdt_pkg::OP_REG,  16'd12,   1'b0, NO_REPLY},
      '{pdt_pkg::OP_REG,  16'd15,   1'b0, NO_REPLY},
      '{pdt_pkg::OP_REG,  16'd16,   1'b0, NO_REPLY},
      '{pdt_pkg::OP_REG,  16'd20,   1'b0, NO_REPLY},
      '{pdt_pkg::OP_REG,  16'd24,   1'b0, NO_REPLY},
      '{pdt_pkg::OP_REG,  16'd30,   1'b0, NO_REPLY},
      '{pdt_pkg::OP_REG,  16'd40,   1'b0, NO_REPLY},
      '{pdt_pkg::OP_REG,  16'd7,    1'b1,
        '{pdt_pkg::KIND_REPLY, pdt_pkg::STATUS_FULL, 4'd0, 16'd0, 1'b1}},
      '{pdt_pkg::OP_REG,  16'd0,    1'b1,
        '{pdt_pkg::KIND_REPLY, pdt_pkg::STATUS_FULL, 4'd0, 16'd0, 1'b1}},
      '{pdt_pkg::OP_TICK, 16'hA5A5, 1'b0, NO_REPLY},
      '{pdt_pkg::OP_TICK, 16'd0,    1'b0, NO_REPLY}
   };

   periodic_tick_dispatcher #(
      .MAX_WATCHERS(WATCHERS)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_op       (req_op),
      .req_period   (req_period),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_kind     (rsp_kind),
      .rsp_status   (rsp_status),
      .rsp_slot     (rsp_slot),
      .rsp_tick_now (rsp_tick_now),
      .rsp_last     (rsp_last)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int unsigned draw_gap();
      if (steady) return 0;
      return $urandom_range(0, MAX_GAP);
   endfunction

   task automatic note_mismatch(input string msg);
      mismatches++;
      $display("MISMATCH: %s", msg);
   endtask

   task automatic compare_field(input string name, input logic [pdt_pkg::TICK_W-1:0] want,
                                input logic [pdt_pkg::TICK_W-1:0] got, input int idx);
      if (got !== want)
         note_mismatch($sformatf("result %0d %s: expected 0x%0h, got 0x%0h",
                                 idx, name, want, got));
   endtask

   task automatic predict_dispatch(input logic op, input logic [pdt_pkg::TICK_W-1:0] period);
      tick_result_type w;
      int hits [$];
      int i;
      w = '0;
      w.last = 1'b1;
      if (op == pdt_pkg::OP_REG) begin
         w.kind = pdt_pkg::KIND_REPLY;
         if (model_watchers >= CAPACITY) begin
            w.status = pdt_pkg::STATUS_FULL;
         end else if (period == '0 || period > pdt_pkg::TICK_LIMIT) begin
            w.status = pdt_pkg::STATUS_BAD;
         end else begin
            model_periods[model_watchers[pdt_pkg::SLOT_W-1:0]] = period;
            w.status = pdt_pkg::STATUS_OK;
            w.slot = model_watchers[pdt_pkg::SLOT_W-1:0];
            model_watchers = model_watchers + 5'd1;
         end
         pending_results.push_back(w);
      end else begin
         model_tick = (model_tick >= pdt_pkg::TICK_LIMIT) ? 16'd1 : model_tick + 16'd1;
         for (i = int'(model_watchers) - 1; i >= 0; i--) begin
            if (model_periods[i] != '0 && (model_tick % model_periods[i]) == '0)
               hits.push_back(i);
         end
         w.kind = pdt_pkg::KIND_FIRE;
         w.status = pdt_pkg::STATUS_OK;
         w.tick_now = model_tick;
         foreach (hits[j]) begin
            w.slot = pdt_pkg::SLOT_W'(hits[j]);
            w.last = (j == hits.size() - 1);
            pending_results.push_back(w);
         end
      end
   endtask

   // Returns at the rising edge at which the word is taken.
   task automatic send_word(input logic op, input logic [pdt_pkg::TICK_W-1:0] period);
      int unsigned gap;
      gap = draw_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_op <= 1'($urandom());
         req_period <= pdt_pkg::TICK_W'($urandom());
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_period <= period;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      words_sent++;
      if (op == pdt_pkg::OP_REG) regs_sent++;
      else ticks_sent++;
   endtask

   // Withdraws the request and waits until every expected result has come.
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int k;
      logic op;
      logic [pdt_pkg::TICK_W-1:0] period;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = pdt_pkg::OP_TICK;
      req_period = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         send_word(directed_rows[r].op, directed_rows[r].period);
         predict_dispatch(directed_rows[r].op, directed_rows[r].period);
         if (directed_rows[r].typed) begin
            void'(pending_results.pop_back());
            pending_results.push_back(directed_rows[r].reply);
         end
      end
      wait_for_drain();

      for (k = 0; k < RANDOM_WORDS; k++) begin
         if (k % 10 == 0) steady = ($urandom_range(0, 3) == 0);
         op = ($urandom_range(0, 3) == 0) ? pdt_pkg::OP_REG : pdt_pkg::OP_TICK;
         case ($urandom_range(0, 3))
            0: period = '0;
            1: period = pdt_pkg::TICK_W'($urandom());
            2: period = pdt_pkg::TICK_W'($urandom_range(1, 40));
            default: period = 16'hFFFF;
         endcase
         send_word(op, period);
         predict_dispatch(op, period);
         if (k == RANDOM_WORDS / 2 || $urandom_range(0, 19) == 0) begin
            wait_for_drain();
         end
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         note_mismatch($sformatf("%0d expected results never arrived",
                                 pending_results.size()));

      $display("Sent %0d words (%0d ticks, %0d registrations) against %0d watchers.",
               words_sent, ticks_sent, regs_sent, model_watchers);
      $display("Checked %0d results, %0d of them fire words; tick count reached %0d.",
               results_seen, fires_seen, model_tick);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin : result_sink
      int unsigned hold;
      tick_result_type got;
      tick_result_type want;
      rsp_stall = 1'b0;
      wait (reset == 1'b0);
      forever begin
         hold = draw_gap();
         @(negedge clock);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         got = '{rsp_kind, rsp_status, rsp_slot, rsp_tick_now, rsp_last};
         if (got.kind === pdt_pkg::KIND_FIRE) fires_seen++;
         if (pending_results.size() == 0) begin
            note_mismatch($sformatf("result %0d arrived with nothing expected: %p",
                                    results_seen, got));
         end else begin
            want = pending_results.pop_front();
            compare_field("kind", pdt_pkg::TICK_W'(want.kind),
                          pdt_pkg::TICK_W'(got.kind), results_seen);
            compare_field("status", pdt_pkg::TICK_W'(want.status),
                          pdt_pkg::TICK_W'(got.status), results_seen);
            compare_field("slot", pdt_pkg::TICK_W'(want.slot),
                          pdt_pkg::TICK_W'(got.slot), results_seen);
            compare_field("tick_now", want.tick_now, got.tick_now, results_seen);
            compare_field("last", pdt_pkg::TICK_W'(want.last),
                          pdt_pkg::TICK_W'(got.last), results_seen);
         end
         results_seen++;
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b1 || (req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles, %0d results outstanding.",
                  quiet_cycles, pending_results.size());
         $display("== FAIL ==");
         $finish;
      end
   end

endmodule
